>>> sv/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

    localparam int TAG_BITS  = 16;
    localparam int PRIO_BITS = 16;
    localparam int OCC_BITS  = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]                  opcode;
        logic [TAG_BITS-1:0]         task_tag;
        logic signed [PRIO_BITS-1:0] task_priority;
    } t_in_word;

    typedef struct packed {
        logic [1:0]                  status;
        logic [TAG_BITS-1:0]         head_tag;
        logic signed [PRIO_BITS-1:0] head_priority;
        logic [OCC_BITS-1:0]         occupancy;
    } t_out_word;

    typedef struct packed {
        logic                        valid;
        logic [TAG_BITS-1:0]         tag;
        logic signed [PRIO_BITS-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic                        insert;
        logic                        remove;
        logic [TAG_BITS-1:0]         tag;
        logic signed [PRIO_BITS-1:0] prio;
    } t_cell_cmd;

endpackage

>>> sv/spq_cell.sv
// One storage cell of the queue chain, holding a single entry.
module spq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  spq_pkg::t_entry   i_left,
    input  logic              i_left_keep,
    input  spq_pkg::t_entry   i_right,
    output spq_pkg::t_entry   o_entry,
    output logic              o_keep
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    assign o_entry = r_entry;
    assign o_keep  = r_entry.valid && ($signed(r_entry.prio) >= $signed(i_cmd.prio));

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.insert) begin
            if (!o_keep) begin
                if (i_left_keep) begin
                    n_entry.valid = 1'b1;
                    n_entry.tag   = i_cmd.tag;
                    n_entry.prio  = i_cmd.prio;
                end else begin
                    n_entry = i_left;
                end
            end
        end else if (i_cmd.remove) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry.tag  <= n_entry.tag;
        r_entry.prio <= n_entry.prio;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

endmodule

>>> sv/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: a chain of cells kept in descending priority order.
// The queue takes one word per clock cycle and delivers its result word in the next cycle
// from an output register; the input stalls only while that register holds a word that the
// output side stalls. An insert compares the new priority against every cell at once and
// each cell either holds, takes the new entry or takes its left neighbour's entry, so an
// insert or remove updates the whole cell chain at once and a peek leaves it unchanged. Equal
// priorities leave in arrival order, and an insert into a full queue is dropped.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  spq_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output spq_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);
    import spq_pkg::*;

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    t_entry    w_entry [CAPACITY];
    logic      w_keep  [CAPACITY];
    t_entry    w_new;
    t_cell_cmd w_cmd;

    logic                r_out_valid;
    logic                n_out_valid;
    t_out_word           r_out_word;
    t_out_word           n_out_word;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic [31:0]         w_count_ext;
    logic                w_fire;
    logic                w_full;
    logic                w_empty;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_fire  = i_in_valid && !o_in_stall;
    assign w_full  = (r_count == CNT_BITS'(CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_new.valid = 1'b1;
    assign w_new.tag   = i_in_word.task_tag;
    assign w_new.prio  = i_in_word.task_priority;

    assign w_cmd.insert = w_fire && (i_in_word.opcode == OP_INSERT) && !w_full;
    assign w_cmd.remove = w_fire && (i_in_word.opcode == OP_REMOVE) && !w_empty;
    assign w_cmd.tag    = i_in_word.task_tag;
    assign w_cmd.prio   = i_in_word.task_priority;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_keep;
        t_entry w_right;

        if (g == 0) begin : g_first
            assign w_left      = w_new;
            assign w_left_keep = 1'b0;
        end else begin : g_inner
            assign w_left      = w_entry[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_entry     (w_entry[g]),
            .o_keep      (w_keep[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.insert) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.remove) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_count_ext = 32'(n_count);

    always_comb begin
        n_out_word           = '0;
        n_out_word.status    = ST_OK;
        n_out_word.occupancy = w_count_ext[OCC_BITS-1:0];
        unique case (i_in_word.opcode)
            OP_INSERT: begin
                if (w_full) begin
                    n_out_word.status = ST_FULL;
                end
            end
            OP_REMOVE, OP_PEEK: begin
                if (w_empty) begin
                    n_out_word.status = ST_EMPTY;
                end else begin
                    n_out_word.head_tag      = w_entry[0].tag;
                    n_out_word.head_priority = w_entry[0].prio;
                end
            end
            default: begin
                n_out_word.status = ST_OK;
            end
        endcase
    end

    assign n_out_valid = w_fire || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_word <= n_out_word;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

endmodule

>>> sv/spq_checker.sv
// Port-level checker for the sorted priority queue and its bind to the top level.
module spq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input spq_pkg::t_in_word  i_in_word,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input spq_pkg::t_out_word o_out_word,
    input logic               i_out_stall
);
    import spq_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid straight after reset");

    a_word_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted word gave no result word");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a waiting result word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ST_EMPTY)) |->
        ((o_out_word.head_tag == '0) && (o_out_word.head_priority == '0)
         && (o_out_word.occupancy == '0)))
        else $error("empty status with a non-zero head or occupancy");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_word   (i_in_word),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);
